FILE: hdl/bli_pkg.sv
// ----------------------------------------------------------------------------
// bli_pkg
// Shared widths and beat types for the bilinear interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package bli_pkg;

    localparam int COORD_BITS  = 16;
    localparam int SAMPLE_BITS = 16;
    // signed product / sum of a sample and a position difference
    localparam int PROD_BITS   = SAMPLE_BITS + COORD_BITS + 1;
    // magnitude of that sum
    localparam int MAG_BITS    = SAMPLE_BITS + COORD_BITS;

    typedef struct packed {
        logic [COORD_BITS-1:0]         left_x;
        logic [COORD_BITS-1:0]         right_x;
        logic [COORD_BITS-1:0]         top_y;
        logic [COORD_BITS-1:0]         bottom_y;
        logic signed [SAMPLE_BITS-1:0] sample_top_left;
        logic signed [SAMPLE_BITS-1:0] sample_top_right;
        logic signed [SAMPLE_BITS-1:0] sample_bottom_left;
        logic signed [SAMPLE_BITS-1:0] sample_bottom_right;
        logic [COORD_BITS-1:0]         query_x;
        logic [COORD_BITS-1:0]         query_y;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] interpolated_value;
        logic                          x_outside;
        logic                          y_outside;
    } t_out;

    // data that rides along a stage untouched
    typedef struct packed {
        logic [COORD_BITS-1:0] p1;
        logic [COORD_BITS-1:0] p2;
        logic [COORD_BITS-1:0] p;
        logic                  flag;
    } t_side;

    // one divider cell's state
    typedef struct packed {
        logic                          valid;
        logic [COORD_BITS-1:0]         rem;
        logic [SAMPLE_BITS-1:0]        low;
        logic [SAMPLE_BITS-1:0]        quo;
        logic [COORD_BITS-1:0]         d;
        logic                          neg;
        logic                          outside;
        logic                          equal;
        logic signed [SAMPLE_BITS-1:0] q1;
        t_side                         side;
    } t_div;

endpackage

`default_nettype wire

FILE: hdl/bli_div_cell.sv
// ----------------------------------------------------------------------------
// bli_div_cell
// One restoring division step: shift in a dividend bit, subtract if it fits.
// ----------------------------------------------------------------------------
`default_nettype none

module bli_div_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire bli_pkg::t_div i_stage,
    output bli_pkg::t_div      o_stage
);

    bli_pkg::t_div r_stage;
    bli_pkg::t_div n_stage;

    logic [bli_pkg::COORD_BITS:0] trial;
    logic [bli_pkg::COORD_BITS:0] diff;
    logic                         fits;

    always_comb begin
        trial = {i_stage.rem, i_stage.low[bli_pkg::SAMPLE_BITS-1]};
        fits  = trial >= {1'b0, i_stage.d};
        diff  = trial - {1'b0, i_stage.d};
        n_stage     = i_stage;
        n_stage.rem = fits ? diff[bli_pkg::COORD_BITS-1:0]
                           : trial[bli_pkg::COORD_BITS-1:0];
        n_stage.low = {i_stage.low[bli_pkg::SAMPLE_BITS-2:0], 1'b0};
        n_stage.quo = {i_stage.quo[bli_pkg::SAMPLE_BITS-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

`default_nettype wire

FILE: hdl/bli_lerp.sv
// ----------------------------------------------------------------------------
// bli_lerp
// One linear interpolation stage: order, weigh, divide through a cell chain,
// round to nearest with ties away from zero (zero when outside, q1 when equal).
// ----------------------------------------------------------------------------
`default_nettype none

module bli_lerp (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_en,
    input  wire logic                                 i_valid,
    input  wire logic [bli_pkg::COORD_BITS-1:0]       i_p1,
    input  wire logic [bli_pkg::COORD_BITS-1:0]       i_p2,
    input  wire logic [bli_pkg::COORD_BITS-1:0]       i_p,
    input  wire logic signed [bli_pkg::SAMPLE_BITS-1:0] i_q1,
    input  wire logic signed [bli_pkg::SAMPLE_BITS-1:0] i_q2,
    input  wire bli_pkg::t_side                       i_side,
    output logic                                      o_valid,
    output logic signed [bli_pkg::SAMPLE_BITS-1:0]    o_value,
    output logic                                      o_outside,
    output bli_pkg::t_side                            o_side
);

    localparam int CW = bli_pkg::COORD_BITS;
    localparam int SW = bli_pkg::SAMPLE_BITS;

    // order and differences
    logic                 r1_valid;
    logic [CW-1:0]        r1_d;
    logic [CW-1:0]        r1_t;
    logic [CW-1:0]        r1_dmt;
    logic                 r1_outside;
    logic                 r1_equal;
    logic signed [SW-1:0] r1_q1;
    logic signed [SW-1:0] r1_q2;
    bli_pkg::t_side       r1_side;

    logic [CW-1:0] lo;
    logic [CW-1:0] hi;

    always_comb begin
        lo = (i_p1 > i_p2) ? i_p2 : i_p1;
        hi = (i_p1 > i_p2) ? i_p1 : i_p2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_d       <= hi - lo;
            r1_t       <= i_p - lo;
            r1_dmt     <= hi - i_p;
            r1_outside <= (i_p < lo) || (i_p > hi);
            r1_equal   <= lo == hi;
            r1_q1      <= i_q1;
            r1_q2      <= i_q2;
            r1_side    <= i_side;
        end
    end

    // weights
    logic                                r2_valid;
    logic signed [bli_pkg::PROD_BITS-1:0] r2_prod1;
    logic signed [bli_pkg::PROD_BITS-1:0] r2_prod2;
    logic [CW-1:0]                       r2_d;
    logic                                r2_outside;
    logic                                r2_equal;
    logic signed [SW-1:0]                r2_q1;
    bli_pkg::t_side                      r2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_prod1   <= r1_q1 * $signed({1'b0, r1_dmt});
            r2_prod2   <= r1_q2 * $signed({1'b0, r1_t});
            r2_d       <= r1_d;
            r2_outside <= r1_outside;
            r2_equal   <= r1_equal;
            r2_q1      <= r1_q1;
            r2_side    <= r1_side;
        end
    end

    // sum, sign and magnitude; seed the divider
    logic signed [bli_pkg::PROD_BITS-1:0] num;
    logic [bli_pkg::PROD_BITS-1:0]        mag;
    bli_pkg::t_div                        n_seed;
    bli_pkg::t_div                        r_seed;

    always_comb begin
        num = r2_prod1 + r2_prod2;
        mag = num[bli_pkg::PROD_BITS-1] ? -num : num;
        n_seed.valid   = r2_valid;
        n_seed.rem     = mag[bli_pkg::MAG_BITS-1:SW];
        n_seed.low     = mag[SW-1:0];
        n_seed.quo     = '0;
        n_seed.d       = r2_d;
        n_seed.neg     = num[bli_pkg::PROD_BITS-1];
        n_seed.outside = r2_outside;
        n_seed.equal   = r2_equal;
        n_seed.q1      = r2_q1;
        n_seed.side    = r2_side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_en) begin
            r_seed <= n_seed;
        end
    end

    // one quotient bit per cell
    bli_pkg::t_div chain [SW+1];

    assign chain[0] = r_seed;

    for (genvar k = 0; k < SW; k++) begin : g_cell
        bli_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_stage (chain[k]),
            .o_stage (chain[k+1])
        );
    end

    // round and select
    bli_pkg::t_div  last;
    logic [SW-1:0]  quo_r;
    logic           up;

    always_comb begin
        last  = chain[SW];
        up    = {last.rem, 1'b0} >= {1'b0, last.d};
        quo_r = last.quo + {{(SW-1){1'b0}}, up};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_outside <= last.outside;
            o_side    <= last.side;
            if (last.outside) begin
                o_value <= '0;
            end else if (last.equal) begin
                o_value <= last.q1;
            end else if (last.neg) begin
                o_value <= -quo_r;
            end else begin
                o_value <= quo_r;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/bilinear_interpolator.sv
// Pipeline: an accepted input beat reaches its output beat through two chained
//   linear stages (each: order, multiply, sum, 16 divider cells, round).
// Throughput: one beat per cycle while not stalled; the 16-cell restoring
//   divider chain in each stage retires one quotient bit per cell per cycle.
// Reset: synchronous, active low; clears all valid bits, no beat in flight.
// ----------------------------------------------------------------------------
// bilinear_interpolator
// Two row interpolations at query_x, then one column interpolation at query_y.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_interpolator (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire bli_pkg::t_in i_data,
    output logic              o_valid,
    input  wire logic         i_stall,
    output bli_pkg::t_out     o_data
);

    // Advance the whole pipeline unless a finished beat is held at the output.
    // The last stage register is the output register, so a new beat is taken
    // in the same cycle the output beat is taken.
    logic en;

    assign o_stall = o_valid && i_stall;
    assign en      = !o_stall;

    // Carry the y fields beside the row stages.
    bli_pkg::t_side side_y;
    bli_pkg::t_side side_top;
    bli_pkg::t_side side_col_in;
    bli_pkg::t_side side_col;
    bli_pkg::t_side side_bot;

    always_comb begin
        side_y.p1   = i_data.top_y;
        side_y.p2   = i_data.bottom_y;
        side_y.p    = i_data.query_y;
        side_y.flag = 1'b0;
    end

    logic                                  top_valid;
    logic                                  bot_valid;
    logic signed [bli_pkg::SAMPLE_BITS-1:0] top_value;
    logic signed [bli_pkg::SAMPLE_BITS-1:0] bot_value;
    logic                                  top_outside;
    logic                                  bot_outside;

    bli_lerp u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_valid),
        .i_p1      (i_data.left_x),
        .i_p2      (i_data.right_x),
        .i_p       (i_data.query_x),
        .i_q1      (i_data.sample_top_left),
        .i_q2      (i_data.sample_top_right),
        .i_side    (side_y),
        .o_valid   (top_valid),
        .o_value   (top_value),
        .o_outside (top_outside),
        .o_side    (side_top)
    );

    bli_lerp u_bot (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_valid),
        .i_p1      (i_data.left_x),
        .i_p2      (i_data.right_x),
        .i_p       (i_data.query_x),
        .i_q1      (i_data.sample_bottom_left),
        .i_q2      (i_data.sample_bottom_right),
        .i_side    (side_y),
        .o_valid   (bot_valid),
        .o_value   (bot_value),
        .o_outside (bot_outside),
        .o_side    (side_bot)
    );

    // Hand the x flag to the column stage through its side data.
    always_comb begin
        side_col_in      = side_top;
        side_col_in.flag = top_outside;
    end

    logic                                  col_outside;
    logic signed [bli_pkg::SAMPLE_BITS-1:0] col_value;

    bli_lerp u_col (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (top_valid),
        .i_p1      (side_top.p1),
        .i_p2      (side_top.p2),
        .i_p       (side_top.p),
        .i_q1      (top_value),
        .i_q2      (bot_value),
        .i_side    (side_col_in),
        .o_valid   (o_valid),
        .o_value   (col_value),
        .o_outside (col_outside),
        .o_side    (side_col)
    );

    always_comb begin
        o_data.interpolated_value = col_value;
        o_data.x_outside          = side_col.flag;
        o_data.y_outside          = col_outside;
    end

    // Both rows move in lockstep.
    a_rows_lockstep : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        top_valid == bot_valid)
        else $error("row stages out of step");

    // Both rows see the same x interval.
    a_rows_same_flag : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        top_valid |-> (top_outside == bot_outside))
        else $error("row stages disagree on x range");

    // An out-of-range query yields zero.
    a_outside_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.x_outside || o_data.y_outside)
            |-> (o_data.interpolated_value == '0))
        else $error("out-of-range beat with nonzero value");

    // Input is held back only while an output beat waits.
    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output");

    // Unused side data from the bottom row.
    logic unused_bot;
    assign unused_bot = ^side_bot;

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bilinear interpolator: a directed table, then
// random neighborhoods, all scored against an in-bench interpolation model.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_RANDOM  = 1250;
    localparam int LATENCY     = 40;
    localparam int HOLD_CYCLES = 300;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_valid = 1'b0;
    logic           o_stall;
    bli_pkg::t_in   i_data = '0;
    logic           o_valid;
    logic           i_stall = 1'b0;
    bli_pkg::t_out  o_data;

    always #1 i_clk = ~i_clk;

    bilinear_interpolator i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    bli_pkg::t_out pending_pixels[$];
    int   mismatches = 0;
    int   pixels_in = 0;
    int   pixels_out = 0;
    int   x_out_seen = 0;
    int   y_out_seen = 0;
    bit   stim_done = 1'b0;
    bit   calm = 1'b0;      // no random idling while set
    bit   hold_rx = 1'b0;   // long receiver hold-off while set

    // One linear stage: swap positions, range check, rounded division.
    function automatic longint lerp1d(input longint p1, input longint p2,
                                      input longint q1, input longint q2,
                                      input longint p, output bit outside);
        longint tmp, d, t, num, mag, quo, rem;
        if (p1 > p2) begin
            tmp = p1; p1 = p2; p2 = tmp;
        end
        outside = (p < p1) || (p > p2);
        if (outside) return 0;
        if (p1 == p2) return q1;
        d   = p2 - p1;
        t   = p - p1;
        num = q1 * (d - t) + q2 * t;
        mag = (num < 0) ? -num : num;
        quo = mag / d;
        rem = mag % d;
        if (rem >= d - rem) quo++;
        return (num < 0) ? -quo : quo;
    endfunction

    function automatic bli_pkg::t_out interpolate(input bli_pkg::t_in px);
        bli_pkg::t_out r;
        bit     xo, xo2, yo;
        longint top, bot, v;
        top = lerp1d(px.left_x, px.right_x, px.sample_top_left,
                     px.sample_top_right, px.query_x, xo);
        bot = lerp1d(px.left_x, px.right_x, px.sample_bottom_left,
                     px.sample_bottom_right, px.query_x, xo2);
        v   = lerp1d(px.top_y, px.bottom_y, top, bot, px.query_y, yo);
        r.interpolated_value = v[bli_pkg::SAMPLE_BITS-1:0];
        r.x_outside = xo;
        r.y_outside = yo;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("MISMATCH pixel %0d %s: got %0d want %0d", pixels_out, what, got, want);
    endtask

    // Random neighborhood: mostly queries inside both intervals.
    function automatic bli_pkg::t_in random_pixel();
        bli_pkg::t_in px;
        px = bli_pkg::t_in'({$urandom, $urandom, $urandom, $urandom, $urandom});
        if ($urandom_range(0, 9) < 8) begin
            if (px.left_x <= px.right_x)
                px.query_x = 16'($urandom_range(px.right_x, px.left_x));
            else
                px.query_x = 16'($urandom_range(px.left_x, px.right_x));
            if (px.top_y <= px.bottom_y)
                px.query_y = 16'($urandom_range(px.bottom_y, px.top_y));
            else
                px.query_y = 16'($urandom_range(px.top_y, px.bottom_y));
        end
        if ($urandom_range(0, 19) == 0) px.right_x = px.left_x;
        if ($urandom_range(0, 19) == 0) px.bottom_y = px.top_y;
        return px;
    endfunction

    // Directed rows; check_want marks rows whose answer is typed in.
    typedef struct {
        bli_pkg::t_in  px;
        bit            check_want;
        bli_pkg::t_out want;
    } t_row;

    t_row table_rows[$];

    task automatic add_row(input bli_pkg::t_in px, input bit chk, input bli_pkg::t_out w);
        t_row r;
        r.px = px; r.check_want = chk; r.want = w;
        table_rows.push_back(r);
    endtask

    function automatic bli_pkg::t_in mk(input int x1, input int x2, input int y1,
                                        input int y2, input int a, input int b,
                                        input int c, input int d,
                                        input int qx, input int qy);
        bli_pkg::t_in px;
        px.left_x = 16'(x1); px.right_x = 16'(x2);
        px.top_y = 16'(y1); px.bottom_y = 16'(y2);
        px.sample_top_left = 16'(a); px.sample_top_right = 16'(b);
        px.sample_bottom_left = 16'(c); px.sample_bottom_right = 16'(d);
        px.query_x = 16'(qx); px.query_y = 16'(qy);
        return px;
    endfunction

    function automatic bli_pkg::t_out res(input int v, input bit xo, input bit yo);
        bli_pkg::t_out r;
        r.interpolated_value = 16'(v); r.x_outside = xo; r.y_outside = yo;
        return r;
    endfunction

    bli_pkg::t_out expected_px;
    bli_pkg::t_in  next_px;
    int            row_idx;
    bit            want_check[$];
    bli_pkg::t_out want_value[$];

    initial begin
        // corners, extremes
        add_row(mk(0, 256, 0, 256, 100, 200, 300, 400, 0, 0), 1, res(100, 0, 0));
        add_row(mk(0, 256, 0, 256, 100, 200, 300, 400, 256, 256), 1, res(400, 0, 0));
        add_row(mk(0, 65535, 0, 65535, -32768, 32767, 32767, -32768, 0, 65535),
                1, res(32767, 0, 0));
        add_row(mk(0, 65535, 0, 65535, -32768, 32767, 32767, -32768, 65535, 0),
                1, res(32767, 0, 0));
        add_row(mk(0, 65535, 0, 65535, -32768, -32768, -32768, -32768, 12345, 54321),
                1, res(-32768, 0, 0));
        add_row(mk(0, 65535, 0, 65535, -32768, 32767, -32768, 32767, 32767, 32768),
                0, res(0, 0, 0));
        // query outside x / y / both
        add_row(mk(100, 200, 0, 256, 5, 6, 7, 8, 99, 10), 1, res(0, 1, 0));
        add_row(mk(100, 200, 0, 256, 5, 6, 7, 8, 201, 10), 1, res(0, 1, 0));
        add_row(mk(0, 256, 100, 200, 5, 6, 7, 8, 10, 300), 1, res(0, 0, 1));
        add_row(mk(0, 256, 100, 200, 5, 6, 7, 8, 10, 0), 1, res(0, 0, 1));
        add_row(mk(100, 200, 100, 200, 5, 6, 7, 8, 0, 65535), 1, res(0, 1, 1));
        // swapped positions: samples stay put
        add_row(mk(256, 0, 0, 256, 100, 200, 100, 200, 0, 0), 1, res(100, 0, 0));
        add_row(mk(0, 256, 256, 0, 100, 100, 300, 300, 0, 0), 1, res(100, 0, 0));
        add_row(mk(65535, 0, 65535, 0, -1, 1, 7, -7, 40000, 30000), 0, res(0, 0, 0));
        // equal positions
        add_row(mk(50, 50, 70, 70, -9, 9, 4, 4, 50, 70), 1, res(-9, 0, 0));
        add_row(mk(50, 50, 70, 70, -9, 9, 4, 4, 51, 70), 1, res(0, 1, 0));
        add_row(mk(65535, 65535, 0, 0, 32767, 0, 0, 0, 65535, 0), 1, res(32767, 0, 0));
        // rounding: ties away from zero on both signs
        add_row(mk(0, 2, 0, 0, 0, 1, 0, 0, 1, 0), 1, res(1, 0, 0));
        add_row(mk(0, 2, 0, 0, 0, -1, 0, 0, 1, 0), 1, res(-1, 0, 0));
        add_row(mk(0, 3, 0, 0, 0, 1, 0, 0, 1, 0), 1, res(0, 0, 0));
        add_row(mk(0, 3, 0, 0, 0, 2, 0, 0, 1, 0), 1, res(1, 0, 0));
        add_row(mk(0, 3, 0, 4, 7, -5, 11, 3, 2, 3), 0, res(0, 0, 0));
        add_row(mk(1, 65534, 2, 65533, 32767, -32768, -32768, 32767, 32767, 32768),
                0, res(0, 0, 0));
    end

    // Sender: hold the beat while stalled; advance after acceptance.
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        row_idx = 0;
        while (row_idx < table_rows.size() + NUM_RANDOM) begin
            if (row_idx < table_rows.size()) next_px = table_rows[row_idx].px;
            else next_px = random_pixel();
            // idle at random except during the quiet stretch
            while (!calm && $urandom_range(0, 99) < 7) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_valid <= 1'b1;
            i_data  <= next_px;
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
            // beat accepted at this edge
            expected_px = interpolate(next_px);
            if (row_idx < table_rows.size() && table_rows[row_idx].check_want) begin
                want_check.push_back(1'b1);
                want_value.push_back(table_rows[row_idx].want);
            end else begin
                want_check.push_back(1'b0);
                want_value.push_back(expected_px);
            end
            pending_pixels.push_back(expected_px);
            pixels_in++;
            row_idx++;
            if (row_idx == 400) calm = 1'b1;
            if (row_idx == 600) calm = 1'b0;
            if (row_idx == 800) hold_rx = 1'b1;
        end
        i_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver stall: random idling, plus one long hold-off counted here.
    initial begin
        int hold_n;
        hold_n = 0;
        forever begin
            @(posedge i_clk);
            if (hold_rx && hold_n < HOLD_CYCLES) begin
                hold_n++;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !calm && ($urandom_range(0, 99) < 7);
            end
        end
    end

    // Score every accepted output beat against the oldest expectation.
    always @(posedge i_clk) begin
        bli_pkg::t_out w;
        bit            chk;
        bli_pkg::t_out typed;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("unexpected beat", o_data.interpolated_value, 0);
            end else begin
                w = pending_pixels.pop_front();
                chk = want_check.pop_front();
                typed = want_value.pop_front();
                if (chk && typed != w)
                    report_mismatch("table vs model", w.interpolated_value,
                                    typed.interpolated_value);
                if (o_data.interpolated_value != w.interpolated_value)
                    report_mismatch("interpolated_value", o_data.interpolated_value,
                                    w.interpolated_value);
                if (o_data.x_outside != w.x_outside)
                    report_mismatch("x_outside", o_data.x_outside, w.x_outside);
                if (o_data.y_outside != w.y_outside)
                    report_mismatch("y_outside", o_data.y_outside, w.y_outside);
                x_out_seen += w.x_outside;
                y_out_seen += w.y_outside;
            end
            pixels_out++;
        end
    end

    // Drain, let the pipeline settle, then judge.
    initial begin
        wait (stim_done);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (2 * LATENCY) @(posedge i_clk);
        $display("Ran %0d neighborhoods through, %0d beats back;", pixels_in, pixels_out);
        $display("%0d fell outside x, %0d outside y.", x_out_seen, y_out_seen);
        if (mismatches == 0 && pending_pixels.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #200000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
